@@ hdl/cmrm_pkg.sv @@
// cmrm_pkg: shared types, opcodes and defaults for the compare/move unit
// no dependencies

package cmrm_pkg;

	localparam int NUM_REGS_DEF  = 16;
	localparam int MEM_WORDS_DEF = 4096;

	localparam logic [3:0] OP_CMP_RR  = 4'd0;
	localparam logic [3:0] OP_CMP_RM  = 4'd1;
	localparam logic [3:0] OP_UCMP_RR = 4'd2;
	localparam logic [3:0] OP_UCMP_RM = 4'd3;
	localparam logic [3:0] OP_MOV_RR  = 4'd4;
	localparam logic [3:0] OP_LOAD    = 4'd5;
	localparam logic [3:0] OP_STORE   = 4'd6;
	localparam logic [3:0] OP_JUMP    = 4'd7;
	localparam logic [3:0] OP_WREG    = 4'd8;
	localparam logic [3:0] OP_WMEM    = 4'd9;
	localparam logic [3:0] OP_RREG    = 4'd10;

	localparam logic signed [1:0] FLAG_GT = 2'sb01;
	localparam logic signed [1:0] FLAG_EQ = 2'sb00;
	localparam logic signed [1:0] FLAG_LT = 2'sb11;

	typedef struct packed {
		logic [3:0]  op;
		logic        wide;
		logic [3:0]  first_reg;
		logic [3:0]  second_reg;
		logic [11:0] address;
		logic [31:0] host_value;
	} in_t;

	typedef struct packed {
		logic signed [1:0] compare_flag;
		logic              jump_taken;
		logic [11:0]       new_ip;
		logic [31:0]       read_data;
	} out_t;

	typedef struct packed {
		in_t        item;
		logic       is_cmp;
		logic       uns;
		logic       rm;
		logic       mrd;
		logic       rwr;
		logic       rwr2;
		logic       mwr;
		logic [2:0] nwords;
	} cmd_t;

endpackage

@@ hdl/cmrm_front.sv @@
// cmrm_front: accepts input transfers and classifies each instruction
// depends on cmrm_pkg

module cmrm_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  cmrm_pkg::in_t cmd,
	input  logic          q_full,
	output logic          q_push,
	output cmrm_pkg::cmd_t q_cmd
);

	logic           v_s1;
	cmrm_pkg::cmd_t cmd_s1;
	cmrm_pkg::cmd_t cls;

	always_comb begin
		cls        = '0;
		cls.item   = cmd;
		unique case (cmd.op)
			cmrm_pkg::OP_CMP_RR: begin
				cls.is_cmp = 1'b1;
			end
			cmrm_pkg::OP_CMP_RM: begin
				cls.is_cmp = 1'b1;
				cls.rm     = 1'b1;
				cls.mrd    = 1'b1;
				cls.nwords = cmd.wide ? 3'd4 : 3'd2;
			end
			cmrm_pkg::OP_UCMP_RR: begin
				cls.is_cmp = 1'b1;
				cls.uns    = 1'b1;
			end
			cmrm_pkg::OP_UCMP_RM: begin
				cls.is_cmp = 1'b1;
				cls.uns    = 1'b1;
				cls.rm     = 1'b1;
				cls.mrd    = 1'b1;
				cls.nwords = 3'd2;
			end
			cmrm_pkg::OP_MOV_RR: begin
				cls.rwr  = 1'b1;
				cls.rwr2 = cmd.wide;
			end
			cmrm_pkg::OP_LOAD: begin
				cls.mrd    = 1'b1;
				cls.rwr    = 1'b1;
				cls.rwr2   = cmd.wide;
				cls.nwords = cmd.wide ? 3'd4 : 3'd2;
			end
			cmrm_pkg::OP_STORE: begin
				cls.mwr    = 1'b1;
				cls.nwords = cmd.wide ? 3'd4 : 3'd2;
			end
			cmrm_pkg::OP_WREG: begin
				cls.rwr = 1'b1;
			end
			cmrm_pkg::OP_WMEM: begin
				cls.mwr    = 1'b1;
				cls.nwords = 3'd1;
			end
			default: begin
			end
		endcase
	end

	assign cmd_stall = v_s1 & q_full;
	assign q_push    = v_s1 & ~q_full;
	assign q_cmd     = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd_valid && !cmd_stall) begin
			v_s1 <= 1'b1;
		end else if (q_push) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			cmd_s1 <= cls;
		end
	end

endmodule

@@ hdl/cmrm_queue.sv @@
// cmrm_queue: two-entry queue between the front and back parts
// depends on cmrm_pkg

module cmrm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  cmrm_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           not_empty,
	output cmrm_pkg::cmd_t head
);

	cmrm_pkg::cmd_t ent_q [2];
	logic           wp_q;
	logic           rp_q;
	logic [1:0]     cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign not_empty = (cnt_q != 2'd0);
	assign head      = ent_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= push_cmd;
		end
	end

endmodule

@@ hdl/cmrm_back.sv @@
// cmrm_back: sequencer that executes instructions on the register file and word memory
// depends on cmrm_pkg

module cmrm_back #(
	parameter int NUM_REGS  = cmrm_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = cmrm_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  cmrm_pkg::cmd_t q_cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output cmrm_pkg::out_t res
);

	localparam int RA_W      = $clog2(NUM_REGS);
	localparam int MA_W      = $clog2(MEM_WORDS);
	localparam bit NEED_WRAP = (MEM_WORDS < 4096);
	localparam int SH        = NEED_WRAP ? (12 - MA_W) : 0;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_WRAP, S_REG0, S_REG1, S_REG2, S_MRD, S_RWR0, S_RWR1, S_MWR, S_FIN
	} state_t;

	state_t            state_q;
	cmrm_pkg::cmd_t    cmd_q;
	logic [RA_W-1:0]   ra_q, rb_q;
	logic [MA_W-1:0]   ma_q, clr_q;
	logic [11:0]       rem_q;
	logic [3:0]        k_q;
	logic [2:0]        cnt_q;
	logic [31:0]       alo_q, ahi_q, blo_q, bhi_q;
	logic [15:0]       w_q [4];
	logic [31:0]       rd0_q, rd1_q;
	logic [15:0]       mrd_q;
	logic signed [1:0] flag_q;
	logic              res_valid_q;
	cmrm_pkg::out_t    res_q;

	logic [31:0]       rf_q [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [15:0]       mem_q [MEM_WORDS];

	logic [RA_W-1:0]   rd_a0, rd_a1, wr_ra;
	logic              rf_we;
	logic [31:0]       rf_wd;
	logic              mem_we;
	logic [MA_W-1:0]   mem_wa;
	logic [15:0]       mem_wd;
	logic [16:0]       dv;
	logic [11:0]       rem_n;
	logic signed [1:0] flag_n;
	logic [63:0]       opa, opb;
	logic [31:0]       opb32;
	logic              out_free;

	function automatic logic [RA_W-1:0] reg_wrap(input logic [3:0] v);
		logic [8:0] t;
		t = {5'd0, v};
		for (int i = 0; i < 8; i++) begin
			if (t >= 9'(NUM_REGS)) begin
				t = t - 9'(NUM_REGS);
			end
		end
		return RA_W'(t);
	endfunction

	function automatic logic [RA_W-1:0] reg_inc(input logic [RA_W-1:0] v);
		return (v == RA_W'(NUM_REGS - 1)) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [MA_W-1:0] mem_inc(input logic [MA_W-1:0] v);
		return (v == MA_W'(MEM_WORDS - 1)) ? '0 : v + 1'b1;
	endfunction

	function automatic logic signed [1:0] cmp_d(input logic [63:0] a, input logic [63:0] b);
		logic nan_a, nan_b, both_zero;
		nan_a     = (&a[62:52]) & (|a[51:0]);
		nan_b     = (&b[62:52]) & (|b[51:0]);
		both_zero = (a[62:0] == 63'd0) && (b[62:0] == 63'd0);
		if (nan_a || nan_b || both_zero || a == b) begin
			return cmrm_pkg::FLAG_EQ;
		end else if (a[63] != b[63]) begin
			return a[63] ? cmrm_pkg::FLAG_LT : cmrm_pkg::FLAG_GT;
		end else if ((a[62:0] > b[62:0]) ^ a[63]) begin
			return cmrm_pkg::FLAG_GT;
		end else begin
			return cmrm_pkg::FLAG_LT;
		end
	endfunction

	// read port addresses
	always_comb begin
		if (state_q == S_REG0) begin
			rd_a0 = (cmd_q.item.op == cmrm_pkg::OP_STORE) ? rb_q : ra_q;
			rd_a1 = rb_q;
		end else begin
			rd_a0 = reg_inc(ra_q);
			rd_a1 = reg_inc(rb_q);
		end
	end

	// register write port
	always_comb begin
		rf_we = (state_q == S_RWR0) || (state_q == S_RWR1);
		if (state_q == S_RWR1) begin
			wr_ra = reg_inc(rb_q);
			rf_wd = (cmd_q.item.op == cmrm_pkg::OP_MOV_RR) ? ahi_q : {w_q[3], w_q[2]};
		end else if (cmd_q.item.op == cmrm_pkg::OP_WREG) begin
			wr_ra = ra_q;
			rf_wd = cmd_q.item.host_value;
		end else begin
			wr_ra = rb_q;
			rf_wd = (cmd_q.item.op == cmrm_pkg::OP_MOV_RR) ? alo_q : {w_q[1], w_q[0]};
		end
	end

	// memory write port
	always_comb begin
		mem_we = (state_q == S_CLR) || (state_q == S_MWR);
		mem_wa = (state_q == S_CLR) ? clr_q : ma_q;
		if (state_q == S_CLR) begin
			mem_wd = '0;
		end else if (cmd_q.item.op == cmrm_pkg::OP_WMEM) begin
			mem_wd = cmd_q.item.host_value[15:0];
		end else begin
			case (cnt_q[1:0])
				2'd0:    mem_wd = alo_q[15:0];
				2'd1:    mem_wd = alo_q[31:16];
				2'd2:    mem_wd = bhi_q[15:0];
				default: mem_wd = bhi_q[31:16];
			endcase
		end
	end

	assign dv    = 17'(MEM_WORDS) << k_q;
	assign rem_n = ({5'd0, rem_q} >= dv) ? (rem_q - dv[11:0]) : rem_q;

	// compare
	always_comb begin
		opa   = {ahi_q, alo_q};
		opb   = cmd_q.rm ? {w_q[3], w_q[2], w_q[1], w_q[0]} : {bhi_q, blo_q};
		opb32 = cmd_q.rm ? {w_q[1], w_q[0]} : blo_q;
		flag_n = flag_q;
		if (cmd_q.is_cmp) begin
			if (cmd_q.uns) begin
				flag_n = (alo_q > opb32) ? cmrm_pkg::FLAG_GT :
					((alo_q < opb32) ? cmrm_pkg::FLAG_LT : cmrm_pkg::FLAG_EQ);
			end else if (cmd_q.item.wide) begin
				flag_n = cmp_d(opa, opb);
			end else begin
				flag_n = ($signed(alo_q) > $signed(opb32)) ? cmrm_pkg::FLAG_GT :
					(($signed(alo_q) < $signed(opb32)) ? cmrm_pkg::FLAG_LT :
					cmrm_pkg::FLAG_EQ);
			end
		end
	end

	assign out_free  = !res_valid_q || !res_stall;
	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_ff @(posedge clk) begin
		rd0_q <= vld_q[rd_a0] ? rf_q[rd_a0] : '0;
		rd1_q <= vld_q[rd_a1] ? rf_q[rd_a1] : '0;
		if (rf_we) begin
			rf_q[wr_ra] <= rf_wd;
		end
	end

	always_ff @(posedge clk) begin
		mrd_q <= mem_q[ma_q];
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			vld_q       <= '0;
			flag_q      <= cmrm_pkg::FLAG_EQ;
			res_valid_q <= 1'b0;
		end else begin
			if (rf_we) begin
				vld_q[wr_ra] <= 1'b1;
			end
			if (res_valid_q && !res_stall && state_q != S_FIN) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= mem_inc(clr_q);
					if (clr_q == MA_W'(MEM_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (q_valid) begin
						state_q <= NEED_WRAP ? S_WRAP : S_REG0;
					end
				end
				S_WRAP: begin
					if (k_q == 4'd0) begin
						state_q <= S_REG0;
					end
				end
				S_REG0: state_q <= S_REG1;
				S_REG1: state_q <= S_REG2;
				S_REG2: begin
					if (cmd_q.mrd) begin
						state_q <= S_MRD;
					end else if (cmd_q.rwr) begin
						state_q <= S_RWR0;
					end else if (cmd_q.mwr) begin
						state_q <= S_MWR;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_MRD: begin
					if (cnt_q == cmd_q.nwords) begin
						state_q <= cmd_q.rwr ? S_RWR0 : S_FIN;
					end
				end
				S_RWR0: state_q <= cmd_q.rwr2 ? S_RWR1 : S_FIN;
				S_RWR1: state_q <= S_FIN;
				S_MWR: begin
					if (cnt_q == cmd_q.nwords - 3'd1) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						flag_q      <= flag_n;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q <= q_cmd;
				ra_q  <= reg_wrap(q_cmd.item.first_reg);
				rb_q  <= reg_wrap(q_cmd.item.second_reg);
				rem_q <= q_cmd.item.address;
				k_q   <= 4'(SH);
				ma_q  <= MA_W'(q_cmd.item.address);
				cnt_q <= '0;
			end
			S_WRAP: begin
				rem_q <= rem_n;
				k_q   <= k_q - 4'd1;
				if (k_q == 4'd0) begin
					ma_q <= MA_W'(rem_n);
				end
			end
			S_REG1: begin
				alo_q <= rd0_q;
				blo_q <= rd1_q;
			end
			S_REG2: begin
				ahi_q <= rd0_q;
				bhi_q <= rd1_q;
			end
			S_MRD: begin
				if (cnt_q != 3'd0) begin
					w_q[2'(cnt_q - 3'd1)] <= mrd_q;
				end
				if (cnt_q != cmd_q.nwords) begin
					ma_q  <= mem_inc(ma_q);
					cnt_q <= cnt_q + 3'd1;
				end else begin
					cnt_q <= '0;
				end
			end
			S_MWR: begin
				ma_q  <= mem_inc(ma_q);
				cnt_q <= cnt_q + 3'd1;
			end
			S_FIN: begin
				if (out_free) begin
					res_q.compare_flag <= flag_n;
					res_q.jump_taken   <= (cmd_q.item.op == cmrm_pkg::OP_JUMP);
					res_q.new_ip       <= (cmd_q.item.op == cmrm_pkg::OP_JUMP) ?
						cmd_q.item.address : 12'd0;
					res_q.read_data    <= (cmd_q.item.op == cmrm_pkg::OP_RREG) ?
						alo_q : 32'd0;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ hdl/register_memory_compare_move_unit.sv @@
// register_memory_compare_move_unit: top level, front classifier, queue and execution sequencer
// from transfer in to result the back sequencer steps through an idle step, three register
// read steps, memory word reads or writes, register writes and a final result step
// the back sequencer runs one instruction at a time, plus 13 - clog2(MEM_WORDS) address steps
// when MEM_WORDS is below 4096; the front and queue take up to three ahead
// reset: after arst_n the word memory is cleared word by word before the first result
// depends on cmrm_pkg, cmrm_front, cmrm_queue, cmrm_back

module register_memory_compare_move_unit #(
	parameter int NUM_REGS  = cmrm_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = cmrm_pkg::MEM_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  cmrm_pkg::in_t  cmd,
	output logic           res_valid,
	input  logic           res_stall,
	output cmrm_pkg::out_t res
);

	logic           q_full, q_push, q_pop, q_nempty;
	cmrm_pkg::cmd_t push_cmd, head_cmd;

	cmrm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (push_cmd)
	);

	cmrm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_nempty),
		.head      (head_cmd)
	);

	cmrm_back #(
		.NUM_REGS  (NUM_REGS),
		.MEM_WORDS (MEM_WORDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_nempty),
		.q_pop     (q_pop),
		.q_cmd     (head_cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule
